// ===== design/csa_pkg.sv =====
// Shared types and constants for the chopped signal amplitude block.
// Used by csa_accum, csa_divsqrt and chopped_signal_amplitude.
`timescale 1ns / 1ps
package csa_pkg;

  localparam int MEAS_W     = 16;
  localparam int AMP_W      = 17;
  localparam int STROBE_W   = 6;
  localparam int PAIRS_W    = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int PROD_W     = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STROBE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIRS  = 2'd2;

  // Register reset values
  localparam logic                RST_MODE   = 1'b1;
  localparam logic [STROBE_W-1:0] RST_STROBE = 6'd20;
  localparam logic [PAIRS_W-1:0]  RST_PAIRS  = 13'd2000;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } dv_op_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dv_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic last;
  } acc_stat_t;

endpackage

// ===== design/csa_accum.sv =====
// Per-pair accumulator: on-phase store, period tracking and running sums.
// Depends on csa_pkg.
`timescale 1ns / 1ps
module csa_accum import csa_pkg::*; #(
  parameter int LW  = 6,
  parameter int PCW = 13,
  parameter int PW  = 7,
  parameter int SW  = 5,
  parameter int MSW = 29,
  parameter int SQW = 46
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic                     clear,
  input  logic signed [MEAS_W-1:0] meas,
  input  logic signed [MEAS_W-1:0] refv,
  input  logic [LW-1:0]            len,
  input  logic [PCW-1:0]           cnt,
  output acc_stat_t                stat,
  output logic [PCW-1:0]           taken,
  output logic [PCW-1:0]           full_periods,
  output logic [SQW-1:0]           square_sum,
  output logic signed [MSW-1:0]    measure_sum,
  output logic signed [MSW-1:0]    reference_sum
);

  localparam int CW = ((PCW > PW) ? PCW : PW) + 1;
  localparam int DEPTH = 1 << SW;

  typedef enum logic [1:0] {
    A_IDLE,
    A_SQ,
    A_ADD
  } acc_state_t;

  acc_state_t state_r;

  logic [PW-1:0]  pos_r;
  logic [PCW-1:0] pcnt_r;
  logic [PCW-1:0] fullp_r;
  logic [SQW-1:0] sq_sum_r;
  logic signed [MSW-1:0] meas_sum_r;
  logic signed [MSW-1:0] ref_sum_r;
  logic counted_r;
  logic off_r;
  logic pend_r;
  logic last_r;
  logic signed [MEAS_W-1:0] meas_r;
  logic signed [MEAS_W-1:0] store_rd_r;
  logic [PROD_W-1:0] prod_r;

  logic signed [MEAS_W-1:0] store_mem [DEPTH];

  logic [PW-1:0]  two_len;
  logic [PW-1:0]  pos_eff;
  logic [PW-1:0]  pos_addr;
  logic           on_phase;
  logic           counted_nxt;
  logic           fits;
  logic [PCW-1:0] taken_nxt;
  logic           last_nxt;
  logic signed [MEAS_W:0]     diff;
  logic signed [2*MEAS_W+1:0] sq;

  assign two_len   = {len, 1'b0};
  assign pos_eff   = (pos_r >= two_len) ? '0 : pos_r;
  assign on_phase  = pos_eff < PW'(len);
  assign pos_addr  = on_phase ? pos_eff : pos_eff - PW'(len);
  // whole period must fit in what is left of the record
  assign fits      = (CW'(pcnt_r) + CW'(two_len)) <= CW'(cnt);
  assign counted_nxt = (pos_eff == '0) ? fits : counted_r;
  assign taken_nxt = pcnt_r + PCW'(1);
  assign last_nxt  = taken_nxt >= cnt;

  assign diff = MEAS_W'(store_rd_r) - MEAS_W'(meas_r);
  assign sq   = diff * diff;

  always_ff @(posedge clk) begin
    if (step && on_phase) begin
      store_mem[pos_addr[SW-1:0]] <= meas;
    end
    store_rd_r <= store_mem[pos_addr[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= A_IDLE;
      pos_r      <= '0;
      pcnt_r     <= '0;
      fullp_r    <= '0;
      sq_sum_r   <= '0;
      meas_sum_r <= '0;
      ref_sum_r  <= '0;
      counted_r  <= 1'b0;
      off_r      <= 1'b0;
      pend_r     <= 1'b0;
      last_r     <= 1'b0;
    end else begin
      unique case (state_r)
        A_IDLE: begin
          if (clear) begin
            pos_r      <= '0;
            pcnt_r     <= '0;
            fullp_r    <= '0;
            sq_sum_r   <= '0;
            meas_sum_r <= '0;
            ref_sum_r  <= '0;
            counted_r  <= 1'b0;
          end else if (step) begin
            meas_r     <= meas;
            off_r      <= !on_phase && counted_nxt;
            pend_r     <= (pos_eff == two_len - PW'(1)) && counted_nxt;
            last_r     <= last_nxt;
            counted_r  <= counted_nxt;
            pos_r      <= pos_eff + PW'(1);
            pcnt_r     <= taken_nxt;
            meas_sum_r <= meas_sum_r + MSW'(meas);
            ref_sum_r  <= ref_sum_r + MSW'(refv);
            state_r    <= A_SQ;
          end
        end
        A_SQ: begin
          prod_r  <= off_r ? sq[PROD_W-1:0] : '0;
          state_r <= A_ADD;
        end
        A_ADD: begin
          sq_sum_r <= sq_sum_r + SQW'(prod_r);
          if (pend_r) begin
            fullp_r <= fullp_r + PCW'(1);
          end
          state_r <= A_IDLE;
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

  assign stat.busy     = state_r != A_IDLE;
  assign stat.done     = state_r == A_ADD;
  assign stat.last     = last_r;
  assign taken         = pcnt_r;
  assign full_periods  = fullp_r;
  assign square_sum    = sq_sum_r;
  assign measure_sum   = meas_sum_r;
  assign reference_sum = ref_sum_r;

endmodule

// ===== design/csa_divsqrt.sv =====
// Shared shift-subtract unit: unsigned divide (one quotient bit per cycle)
// or integer square root (one root bit per cycle). Depends on csa_pkg.
`timescale 1ns / 1ps
module csa_divsqrt import csa_pkg::*; #(
  parameter int SQW = 46,
  parameter int DW  = 19
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  dv_op_t         op,
  input  logic [SQW-1:0] num,
  input  logic [DW-1:0]  den,
  output dv_stat_t       stat,
  output logic [SQW-1:0] quot
);

  localparam int RW = ((DW + 1) > (SQW / 2 + 2)) ? (DW + 1) : (SQW / 2 + 2);
  localparam int NW = $clog2(SQW + 1);

  typedef enum logic {
    U_IDLE,
    U_RUN
  } unit_state_t;

  unit_state_t state_r;
  dv_op_t         op_r;
  logic [SQW-1:0] wr_r;
  logic [RW-1:0]  rem_r;
  logic [SQW-1:0] q_r;
  logic [DW-1:0]  den_r;
  logic [NW-1:0]  cnt_r;
  logic           done_r;

  logic [RW-1:0] cand;
  logic [RW-1:0] opnd;
  logic [RW:0]   diff;
  logic          ge;

  always_comb begin
    if (op_r == OP_SQRT) begin
      cand = {rem_r[RW-3:0], wr_r[SQW-1:SQW-2]};
      opnd = {q_r[RW-3:0], 2'b01};
    end else begin
      cand = {rem_r[RW-2:0], wr_r[SQW-1]};
      opnd = RW'(den_r);
    end
  end

  assign diff = {1'b0, cand} - {1'b0, opnd};
  assign ge   = !diff[RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        U_IDLE: begin
          if (start) begin
            op_r    <= op;
            wr_r    <= num;
            den_r   <= den;
            rem_r   <= '0;
            q_r     <= '0;
            cnt_r   <= (op == OP_SQRT) ? NW'(SQW / 2) : NW'(SQW);
            state_r <= U_RUN;
          end
        end
        U_RUN: begin
          rem_r <= ge ? diff[RW-1:0] : cand;
          q_r   <= {q_r[SQW-2:0], ge};
          wr_r  <= (op_r == OP_SQRT) ? {wr_r[SQW-3:0], 2'b00} : {wr_r[SQW-2:0], 1'b0};
          cnt_r <= cnt_r - NW'(1);
          if (cnt_r == NW'(1)) begin
            done_r  <= 1'b1;
            state_r <= U_IDLE;
          end
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  assign stat.busy = state_r != U_IDLE;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule

// ===== design/chopped_signal_amplitude.sv =====
// Chopper amplitude estimator, top level: config registers, record-end
// sequencer and output register. Depends on csa_pkg, csa_accum, csa_divsqrt.
//
// Usage: sample pairs (measure, reference) arrive on the in_ channel with
// valid/stall; one result beat leaves on the out_ channel after every
// pair_count pairs. Configuration writes use cfg_valid/cfg_ready (always
// ready) with cfg_index 0 = chopper_mode, 1 = strobe_length, 2 = pair_count.
// Each pair passes the accumulator steps store read, square and add;
// in_stall is high after every accepted beat until the add is done.
// After the last pair of a record the shared shift-subtract unit runs a
// divide for the reference mean, a divide for the amplitude and, in chopper
// mode, a square root; a chopper record with no full period skips both
// of the latter. The unit width SQW is 32 + clog2(MAX_PAIRS + 1), rounded
// up to even; in_stall stays high until the result is loaded for output.
// Reset clears the running sums and counters and loads the register
// defaults; the on-phase store is not cleared. The result waits in the
// output register while out_stall is high; pairs of the next record are
// accepted meanwhile, and the next record end waits until that beat leaves.
`timescale 1ns / 1ps
module chopped_signal_amplitude import csa_pkg::*; #(
  parameter int MAX_STROBE = 32,
  parameter int MAX_PAIRS  = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [MEAS_W-1:0]   in_measure_sample,
  input  logic signed [MEAS_W-1:0]   in_reference_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [AMP_W-1:0]    out_amplitude,
  output logic signed [MEAS_W-1:0]   out_reference_mean,
  output logic                       out_no_full_period,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int LW   = $clog2(MAX_STROBE + 1);
  localparam int PCW  = $clog2(MAX_PAIRS + 1);
  localparam int PW   = LW + 1;
  localparam int SW   = (MAX_STROBE > 1) ? $clog2(MAX_STROBE) : 1;
  localparam int MSW  = MEAS_W + PCW;
  localparam int SQW  = PROD_W + PCW + (PCW % 2);
  localparam int DW   = PCW + LW;
  localparam int LCW  = (LW > STROBE_W) ? LW : STROBE_W;
  localparam int PCCW = (PCW > PAIRS_W) ? PCW : PAIRS_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_MUL,
    ST_RGO,
    ST_RWT,
    ST_AGO,
    ST_AWT,
    ST_SGO,
    ST_SWT,
    ST_OUT
  } seq_state_t;

  seq_state_t state_r;

  logic                mode_r;
  logic [STROBE_W-1:0] strobe_r;
  logic [PAIRS_W-1:0]  pairs_r;

  logic                      out_valid_r;
  logic signed [AMP_W-1:0]   amp_r;
  logic signed [MEAS_W-1:0]  rmean_r;
  logic                      flag_r;
  logic [DW-1:0]             terms_r;

  logic [LCW-1:0]  strobe_ext;
  logic [LCW-1:0]  len_full;
  logic [LW-1:0]   len;
  logic [PCCW-1:0] pairs_ext;
  logic [PCCW-1:0] cnt_full;
  logic [PCW-1:0]  cnt;

  logic                  acc_step;
  logic                  acc_clear;
  acc_stat_t             acc_stat;
  logic [PCW-1:0]        taken;
  logic [PCW-1:0]        fullp;
  logic [SQW-1:0]        sq_sum;
  logic signed [MSW-1:0] meas_sum;
  logic signed [MSW-1:0] ref_sum;
  logic [MSW-1:0]        meas_mag;
  logic [MSW-1:0]        ref_mag;

  logic           dv_start;
  dv_op_t         dv_op;
  logic [SQW-1:0] dv_num;
  logic [DW-1:0]  dv_den;
  dv_stat_t       dv_stat;
  logic [SQW-1:0] dv_q;

  logic [MEAS_W-1:0] rq;
  logic [AMP_W-1:0]  aq;
  logic              out_free;

  // effective strobe length and pair count, clamped into range
  assign strobe_ext = LCW'(strobe_r);
  assign len_full   = (strobe_ext == '0) ? LCW'(1) :
                      (strobe_ext > LCW'(MAX_STROBE)) ? LCW'(MAX_STROBE) : strobe_ext;
  assign len        = len_full[LW-1:0];
  assign pairs_ext  = PCCW'(pairs_r);
  assign cnt_full   = (pairs_ext == '0) ? PCCW'(1) :
                      (pairs_ext > PCCW'(MAX_PAIRS)) ? PCCW'(MAX_PAIRS) : pairs_ext;
  assign cnt        = cnt_full[PCW-1:0];

  assign in_stall  = state_r != ST_IDLE;
  assign acc_step  = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign acc_clear = (state_r == ST_OUT) && out_free;
  assign cfg_ready = 1'b1;

  assign meas_mag = meas_sum[MSW-1] ? MSW'(-meas_sum) : MSW'(meas_sum);
  assign ref_mag  = ref_sum[MSW-1] ? MSW'(-ref_sum) : MSW'(ref_sum);

  assign rq = dv_q[MEAS_W-1:0];
  assign aq = dv_q[AMP_W-1:0];

  always_comb begin
    dv_start = 1'b0;
    dv_op    = OP_DIV;
    dv_num   = SQW'(ref_mag);
    dv_den   = DW'(taken);
    case (state_r)
      ST_RGO: dv_start = 1'b1;
      ST_AGO: begin
        dv_start = 1'b1;
        if (mode_r) begin
          dv_num = sq_sum;
          dv_den = terms_r;
        end else begin
          dv_num = SQW'(meas_mag);
        end
      end
      ST_SGO: begin
        dv_start = 1'b1;
        dv_op    = OP_SQRT;
        dv_num   = dv_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= RST_MODE;
      strobe_r <= RST_STROBE;
      pairs_r  <= RST_PAIRS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_data[0];
        CFG_STROBE: strobe_r <= cfg_data[STROBE_W-1:0];
        CFG_PAIRS:  pairs_r  <= cfg_data[PAIRS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (acc_step) begin
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (acc_stat.done) begin
            state_r <= acc_stat.last ? ST_MUL : ST_IDLE;
          end
        end
        ST_MUL: begin
          terms_r <= fullp * len;
          flag_r  <= 1'b0;
          state_r <= ST_RGO;
        end
        ST_RGO: state_r <= ST_RWT;
        ST_RWT: begin
          if (dv_stat.done) begin
            rmean_r <= ref_sum[MSW-1] ? -rq : rq;
            if (mode_r && fullp == '0) begin
              amp_r   <= '0;
              flag_r  <= 1'b1;
              state_r <= ST_OUT;
            end else begin
              state_r <= ST_AGO;
            end
          end
        end
        ST_AGO: state_r <= ST_AWT;
        ST_AWT: begin
          if (dv_stat.done) begin
            if (mode_r) begin
              state_r <= ST_SGO;
            end else begin
              amp_r   <= meas_sum[MSW-1] ? -aq : aq;
              state_r <= ST_OUT;
            end
          end
        end
        ST_SGO: state_r <= ST_SWT;
        ST_SWT: begin
          if (dv_stat.done) begin
            amp_r   <= aq;
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r        <= 1'b1;
            out_amplitude      <= amp_r;
            out_reference_mean <= rmean_r;
            out_no_full_period <= flag_r;
            state_r            <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

  csa_accum #(
    .LW  (LW),
    .PCW (PCW),
    .PW  (PW),
    .SW  (SW),
    .MSW (MSW),
    .SQW (SQW)
  ) u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (acc_step),
    .clear         (acc_clear),
    .meas          (in_measure_sample),
    .refv          (in_reference_sample),
    .len           (len),
    .cnt           (cnt),
    .stat          (acc_stat),
    .taken         (taken),
    .full_periods  (fullp),
    .square_sum    (sq_sum),
    .measure_sum   (meas_sum),
    .reference_sum (ref_sum)
  );

  csa_divsqrt #(
    .SQW (SQW),
    .DW  (DW)
  ) u_divsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .op    (dv_op),
    .num   (dv_num),
    .den   (dv_den),
    .stat  (dv_stat),
    .quot  (dv_q)
  );

  a_flag_zero_amp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_full_period) |-> (out_amplitude == '0))
    else $error("no_full_period beat with nonzero amplitude");

  a_unit_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dv_start |-> !dv_stat.busy)
    else $error("shared unit started while busy");

  a_acc_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc_step |-> !acc_stat.busy)
    else $error("pair accepted while accumulator busy");

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc_clear |-> (!acc_stat.busy && !dv_stat.busy))
    else $error("record cleared while work in flight");

endmodule
